// ----- design/tle_pkg.sv -----
`default_nettype none

package tle_pkg;

    // Line buffer depth and the counter width that holds any fill level.
    localparam int LINE_DEPTH = 256;
    localparam int CNT_W      = $clog2(LINE_DEPTH);
    localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

    // Access kinds carried by func.
    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Operation decided by the front end for each item.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHAR,
        OP_ERASE,
        OP_EOL,
        OP_READ,
        OP_RELEASE
    } op_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [7:0] idx;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/tle_ram.sv -----
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/tle_front.sv -----
`default_nettype none

module tle_front import tle_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [7:0] rx_char,
    input  wire logic [7:0] read_index,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       q_full
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;
    op_t  op_class;

    // Decide what the back end has to do with the item.
    always_comb
    begin
        op_class = OP_NONE;
        case (func)
            FUNC_RX:
            begin
                if (rx_char == CH_BS || rx_char == CH_DEL)
                begin
                    op_class = OP_ERASE;
                end
                else if (rx_char == CH_CR || rx_char == CH_LF)
                begin
                    op_class = OP_EOL;
                end
                else if (rx_char >= CH_SPACE && rx_char <= CH_TILDE)
                begin
                    op_class = OP_CHAR;
                end
            end
            FUNC_READ:    op_class = OP_READ;
            FUNC_RELEASE: op_class = OP_RELEASE;
            default:      op_class = OP_NONE;
        endcase
    end

    // One holding register in front of the queue.
    assign push     = cmd_valid_reg && !q_full;
    assign push_cmd = cmd_reg;
    assign in_stall = cmd_valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (push)
        begin
            cmd_valid_next = 1'b0;
        end
        if (take)
        begin
            cmd_valid_next = 1'b1;
            cmd_next.op    = op_class;
            cmd_next.ch    = rx_char;
            cmd_next.idx   = read_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// ----- design/tle_queue.sv -----
`default_nettype none

module tle_queue import tle_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      q_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Two-entry ring of classified items.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/tle_back.sv -----
`default_nettype none

module tle_back import tle_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire cmd_t       q_cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            echo_valid,
    output logic [7:0]      echo_char,
    output logic            run_end,
    output logic            line_ready,
    output logic [7:0]      line_length,
    output logic [7:0]      line_char,
    output logic            typing
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    op_t              eff_reg, eff_next;
    logic [1:0]       k_reg, k_next;
    logic [CNT_W-1:0] edit_cnt_reg, edit_cnt_next;
    logic [CNT_W-1:0] lead_reg, lead_next;
    logic [CNT_W-1:0] rdy_cnt_reg, rdy_cnt_next;
    logic [CNT_W-1:0] rdy_off_reg, rdy_off_next;
    logic             rdy_flag_reg, rdy_flag_next;
    logic             bank_reg, bank_next;
    logic [7:0]       lchar_reg, lchar_next;

    logic             out_valid_reg, out_valid_next;
    logic             echo_valid_reg, echo_valid_next;
    logic [7:0]       echo_char_reg, echo_char_next;
    logic             run_end_reg, run_end_next;
    logic             line_ready_reg, line_ready_next;
    logic [7:0]       line_length_reg, line_length_next;
    logic [7:0]       line_char_reg, line_char_next;
    logic             typing_reg, typing_next;

    logic             out_free;
    logic             last;
    logic             ram_we;
    logic [CNT_W-1:0] rd_addr;
    logic [7:0]       rd_data_b0;
    logic [7:0]       rd_data_b1;
    logic [7:0]       rd_data;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] addr_sum;
    logic [CMP_W-1:0] len_ext;
    logic             hit;

    // Pending-line lookup: the stored line starts at an offset in its bank.
    assign idx_ext  = CMP_W'(cmd_reg.idx);
    assign addr_sum = CMP_W'(rdy_off_reg) + idx_ext;
    assign rd_addr  = addr_sum[CNT_W-1:0];
    assign hit      = idx_ext < CMP_W'(rdy_cnt_reg);
    assign rd_data  = bank_reg ? rd_data_b0 : rd_data_b1;
    assign len_ext  = CMP_W'(rdy_cnt_reg);

    // The two banks trade roles whenever a line is handed over.
    tle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_bank0 (
        .clk     (clk),
        .wr_en   (ram_we && !bank_reg),
        .wr_addr (edit_cnt_reg),
        .wr_data (cmd_reg.ch),
        .rd_addr (rd_addr),
        .rd_data (rd_data_b0)
    );

    tle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_bank1 (
        .clk     (clk),
        .wr_en   (ram_we && bank_reg),
        .wr_addr (edit_cnt_reg),
        .wr_data (cmd_reg.ch),
        .rd_addr (rd_addr),
        .rd_data (rd_data_b1)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign last     = (eff_reg == OP_ERASE || eff_reg == OP_EOL) ? (k_reg == 2'd2) : 1'b1;

    // Sequencer: take an item, update the line state, then emit its results.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        eff_next         = eff_reg;
        k_next           = k_reg;
        edit_cnt_next    = edit_cnt_reg;
        lead_next        = lead_reg;
        rdy_cnt_next     = rdy_cnt_reg;
        rdy_off_next     = rdy_off_reg;
        rdy_flag_next    = rdy_flag_reg;
        bank_next        = bank_reg;
        lchar_next       = lchar_reg;
        ram_we           = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        echo_valid_next  = echo_valid_reg;
        echo_char_next   = echo_char_reg;
        run_end_next     = run_end_reg;
        line_ready_next  = line_ready_reg;
        line_length_next = line_length_reg;
        line_char_next   = line_char_reg;
        typing_next      = typing_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                k_next     = 2'd0;
                eff_next   = OP_NONE;
                state_next = S_EMIT;
                case (cmd_reg.op)
                    OP_CHAR, OP_ERASE, OP_EOL:
                    begin
                        if (edit_cnt_reg >= CNT_W'(LINE_DEPTH - 1))
                        begin
                            // Overflow drops the partial line without echo.
                            edit_cnt_next = '0;
                            lead_next     = '0;
                        end
                        else if (cmd_reg.op == OP_CHAR)
                        begin
                            ram_we        = 1'b1;
                            edit_cnt_next = edit_cnt_reg + 1'b1;
                            if (lead_reg == edit_cnt_reg && cmd_reg.ch == CH_SPACE)
                            begin
                                lead_next = lead_reg + 1'b1;
                            end
                            eff_next = OP_CHAR;
                        end
                        else if (cmd_reg.op == OP_ERASE)
                        begin
                            if (edit_cnt_reg != '0)
                            begin
                                edit_cnt_next = edit_cnt_reg - 1'b1;
                                if (lead_reg == edit_cnt_reg)
                                begin
                                    lead_next = edit_cnt_reg - 1'b1;
                                end
                                eff_next = OP_ERASE;
                            end
                        end
                        else
                        begin
                            // A line with a non-space character is handed over
                            // by swapping banks, with the leading spaces skipped.
                            if (lead_reg < edit_cnt_reg)
                            begin
                                rdy_off_next  = lead_reg;
                                rdy_cnt_next  = edit_cnt_reg - lead_reg;
                                rdy_flag_next = 1'b1;
                                bank_next     = !bank_reg;
                            end
                            edit_cnt_next = '0;
                            lead_next     = '0;
                            eff_next      = OP_EOL;
                        end
                    end
                    OP_READ:
                    begin
                        eff_next   = OP_READ;
                        state_next = S_READ;
                    end
                    OP_RELEASE:
                    begin
                        rdy_flag_next = 1'b0;
                        rdy_cnt_next  = '0;
                    end
                    default:
                    begin
                        eff_next = OP_NONE;
                    end
                endcase
            end

            S_READ:
            begin
                lchar_next = hit ? rd_data : 8'h00;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    run_end_next     = last;
                    line_ready_next  = rdy_flag_reg;
                    line_length_next = len_ext[7:0];
                    typing_next      = (edit_cnt_reg != '0);
                    line_char_next   = (eff_reg == OP_READ) ? lchar_reg : 8'h00;
                    echo_valid_next  = 1'b1;
                    case (eff_reg)
                        OP_CHAR:  echo_char_next = cmd_reg.ch;
                        OP_ERASE: echo_char_next = (k_reg == 2'd1) ? CH_SPACE : CH_BS;
                        OP_EOL:
                        begin
                            if (k_reg == 2'd0)
                            begin
                                echo_char_next = cmd_reg.ch;
                            end
                            else if (k_reg == 2'd1)
                            begin
                                echo_char_next = CH_CR;
                            end
                            else
                            begin
                                echo_char_next = CH_LF;
                            end
                        end
                        default:
                        begin
                            echo_valid_next = 1'b0;
                            echo_char_next  = 8'h00;
                        end
                    endcase
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            edit_cnt_reg  <= '0;
            lead_reg      <= '0;
            rdy_cnt_reg   <= '0;
            rdy_off_reg   <= '0;
            rdy_flag_reg  <= 1'b0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edit_cnt_reg  <= edit_cnt_next;
            lead_reg      <= lead_next;
            rdy_cnt_reg   <= rdy_cnt_next;
            rdy_off_reg   <= rdy_off_next;
            rdy_flag_reg  <= rdy_flag_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload and result fields.
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        eff_reg         <= eff_next;
        k_reg           <= k_next;
        lchar_reg       <= lchar_next;
        echo_valid_reg  <= echo_valid_next;
        echo_char_reg   <= echo_char_next;
        run_end_reg     <= run_end_next;
        line_ready_reg  <= line_ready_next;
        line_length_reg <= line_length_next;
        line_char_reg   <= line_char_next;
        typing_reg      <= typing_next;
    end

    assign out_valid   = out_valid_reg;
    assign echo_valid  = echo_valid_reg;
    assign echo_char   = echo_char_reg;
    assign run_end     = run_end_reg;
    assign line_ready  = line_ready_reg;
    assign line_length = line_length_reg;
    assign line_char   = line_char_reg;
    assign typing      = typing_reg;

endmodule

`default_nettype wire

// ----- design/terminal_line_editor_core.sv -----
`default_nettype none

// Receive-side line editor for a serial console. Each item is a received byte
// (func 0), a read of one byte of the pending line (func 1) or a release of the
// pending line (func 2). Every item produces one result, or three for an erase
// of a character (BS, space, BS) or a line end (the terminator, CR, LF) unless
// the line has overflowed; run_end marks the last one. The front end classifies
// and holds one item, a two-entry queue follows, and the back end sequencer does
// the work: it takes an item, executes it, does one registered memory read for
// a read of the pending line, and then emits each result, holding while the
// output is stalled. A finished line is handed over by swapping the two line
// memories, so a line end needs no copy of the line.
module terminal_line_editor_core import tle_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [7:0] rx_char,
    input  wire logic [7:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            echo_valid,
    output logic [7:0]      echo_char,
    output logic            run_end,
    output logic            line_ready,
    output logic [7:0]      line_length,
    output logic [7:0]      line_char,
    output logic            typing
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    tle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .rx_char    (rx_char),
        .read_index (read_index),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    tle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_valid  (echo_valid),
        .echo_char   (echo_char),
        .run_end     (run_end),
        .line_ready  (line_ready),
        .line_length (line_length),
        .line_char   (line_char),
        .typing      (typing)
    );

endmodule

`default_nettype wire
